/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the price path step block
// Command format between front and back, register map, fixed-point constants
// and the reciprocal table used by the exp() polynomial.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Register map, index = paddr[5:3]
	localparam logic [2:0] REG_MODEL_MODE     = 3'd0;
	localparam logic [2:0] REG_START_PRICE    = 3'd1;
	localparam logic [2:0] REG_DRIFT_COEF     = 3'd2;
	localparam logic [2:0] REG_DIFFUSION_COEF = 3'd3;
	localparam logic [2:0] REG_STEP_LIMIT     = 3'd4;

	localparam int unsigned PADDR_W = 6;
	localparam int unsigned PDATA_W = 64;

	// Fixed-point constants
	localparam logic [43:0]        PRICE_MAX  = 44'hFFF_FFFF_FFFF;
	localparam logic [43:0]        START_RST  = 44'd1677721600;
	localparam logic [31:0]        LN2_Q32    = 32'd2977044472;
	localparam logic [16:0]        RECIP_LN2  = 17'((64'd1 << 48) / 64'd2977044472);
	localparam logic signed [63:0] E_CLAMP    = 64'sh0000_0040_0000_0000;
	localparam logic [29:0]        ONE_Q28    = 30'd1 << 28;
	localparam logic [3:0]         POLY_TERMS = 4'd10;

	// Command queue
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_RESTART,
		OP_STEP,
		OP_OVERRUN
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic signed [15:0] z;
		logic [15:0]        step_index;
		logic               last;
		logic               overrun;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic        model_mode;
		logic [43:0] start_price;
		logic [47:0] drift_coef;
		logic [47:0] diffusion_coef;
		logic [15:0] step_limit;
	} cfg_t;

	// ceil(2^36 / n); exact floor division for dividends below 2^29.
	// n = 1 bypasses the multiply.
	function automatic logic [35:0] recip_n(input logic [3:0] n);
		logic [35:0] m;
		unique case (n)
			4'd2:    m = 36'd34359738368;
			4'd3:    m = 36'd22906492246;
			4'd4:    m = 36'd17179869184;
			4'd5:    m = 36'd13743895348;
			4'd6:    m = 36'd11453246123;
			4'd7:    m = 36'd9817068106;
			4'd8:    m = 36'd8589934592;
			4'd9:    m = 36'd7635497416;
			4'd10:   m = 36'd6871947674;
			default: m = 36'd0;
		endcase
		return m;
	endfunction

endpackage

/* design/pps_if.sv */
// ----------------------------------------------------------------------------
// pps_if: stream channels of the price path step block
// Sample channel (restart or step) and result channel (price and status).
// ----------------------------------------------------------------------------
interface pps_sample_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] z;

	modport source (output valid, output kind, output z, input ready);
	modport sink   (input valid, input kind, input z, output ready);
endinterface

interface pps_result_if;
	logic        valid;
	logic        ready;
	logic [43:0] price;
	logic [15:0] step_index;
	logic        last;
	logic        overrun;

	modport source (output valid, output price, output step_index, output last,
		output overrun, input ready);
	modport sink   (input valid, input price, input step_index, input last,
		input overrun, output ready);
endinterface

/* design/pps_regs.sv */
// ----------------------------------------------------------------------------
// pps_regs: configuration registers
// APB write/read of mode, start price, coefficients and step limit.
// ----------------------------------------------------------------------------
module pps_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pps_pkg::PADDR_W-1:0]   paddr,
	input  logic [pps_pkg::PDATA_W-1:0]   pwdata,
	output logic [pps_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output pps_pkg::cfg_t                 cfg
);

	pps_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.model_mode     <= 1'b0;
			cfg_q.start_price    <= pps_pkg::START_RST;
			cfg_q.drift_coef     <= '0;
			cfg_q.diffusion_coef <= '0;
			cfg_q.step_limit     <= 16'd1;
		end else if (wr_en) begin
			unique case (idx)
				pps_pkg::REG_MODEL_MODE:     cfg_q.model_mode     <= pwdata[0];
				pps_pkg::REG_START_PRICE:    cfg_q.start_price    <= pwdata[43:0];
				pps_pkg::REG_DRIFT_COEF:     cfg_q.drift_coef     <= pwdata[47:0];
				pps_pkg::REG_DIFFUSION_COEF: cfg_q.diffusion_coef <= pwdata[47:0];
				pps_pkg::REG_STEP_LIMIT:     cfg_q.step_limit     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			pps_pkg::REG_MODEL_MODE:     prdata = {63'd0, cfg_q.model_mode};
			pps_pkg::REG_START_PRICE:    prdata = {20'd0, cfg_q.start_price};
			pps_pkg::REG_DRIFT_COEF:     prdata = {16'd0, cfg_q.drift_coef};
			pps_pkg::REG_DIFFUSION_COEF: prdata = {16'd0, cfg_q.diffusion_coef};
			pps_pkg::REG_STEP_LIMIT:     prdata = {48'd0, cfg_q.step_limit};
			default:                     prdata = '0;
		endcase
	end

endmodule

/* design/pps_front.sv */
// ----------------------------------------------------------------------------
// pps_front: sample intake and classification
// Tracks the step count, sorts each sample into restart, step or overrun
// and fills in the result status fields before queueing it.
// ----------------------------------------------------------------------------
module pps_front (
	input  logic                  clk,
	input  logic                  arst_n,
	pps_sample_if.sink            sample,
	input  logic [15:0]           step_limit,
	input  pps_pkg::q_status_t    q_st,
	output logic                  push,
	output pps_pkg::cmd_t         cmd
);

	logic [15:0] step_count_q;
	logic [15:0] count_inc;
	logic [15:0] count_next;

	assign sample.ready = ~q_st.full;
	assign push         = sample.valid & ~q_st.full;
	assign count_inc    = step_count_q + 16'd1;

	// classify
	always_comb begin
		cmd.z = sample.z;
		if (!sample.kind) begin
			cmd.op         = pps_pkg::OP_RESTART;
			cmd.step_index = 16'd0;
			cmd.last       = (step_limit == 16'd0);
			cmd.overrun    = 1'b0;
			count_next     = 16'd0;
		end else if (step_count_q >= step_limit) begin
			cmd.op         = pps_pkg::OP_OVERRUN;
			cmd.step_index = step_count_q;
			cmd.last       = (step_count_q == step_limit);
			cmd.overrun    = 1'b1;
			count_next     = step_count_q;
		end else begin
			cmd.op         = pps_pkg::OP_STEP;
			cmd.step_index = count_inc;
			cmd.last       = (count_inc == step_limit);
			cmd.overrun    = 1'b0;
			count_next     = count_inc;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
		end else if (push) begin
			step_count_q <= count_next;
		end
	end

endmodule

/* design/pps_queue.sv */
// ----------------------------------------------------------------------------
// pps_queue: command queue between front and back
// Small flop FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module pps_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pps_pkg::cmd_t        push_cmd,
	input  logic                 pop,
	output pps_pkg::cmd_t        head,
	output pps_pkg::q_status_t   st
);

	localparam int unsigned CNT_W = $clog2(pps_pkg::QUEUE_DEPTH + 1);

	pps_pkg::cmd_t                entry_q [pps_pkg::QUEUE_DEPTH];
	logic [pps_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pps_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]             count_q;

	assign head     = entry_q[rd_ptr_q];
	assign st.full  = (count_q == CNT_W'(pps_pkg::QUEUE_DEPTH));
	assign st.empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && st.full && !pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && st.empty))
		else $error("queue pop while empty");

endmodule

/* design/pps_back.sv */
// ----------------------------------------------------------------------------
// pps_back: price update engine
// Forms e = drift + diffusion*z, then either adds it (arithmetic mode) or
// multiplies the price by exp(e) through range reduction and a Horner loop.
// ----------------------------------------------------------------------------
module pps_back #(
	parameter int unsigned PRICE_FRAC_BITS = 24,
	parameter int unsigned Z_FRAC_BITS     = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pps_pkg::cfg_t        cfg,
	input  pps_pkg::cmd_t        head,
	input  pps_pkg::q_status_t   q_st,
	output logic                 pop,
	pps_result_if.source         result
);

	localparam int unsigned      ASH   = 32 - PRICE_FRAC_BITS;
	localparam logic [43:0]      FLOOR = 44'(((64'd1 << PRICE_FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic signed [40:0] LN2_S = $signed({9'd0, pps_pkg::LN2_Q32});

	typedef enum logic [3:0] {
		S_IDLE, S_EMUL, S_ARITH, S_CLAMP, S_KEST, S_RSUB, S_RFIX,
		S_PMUL, S_PDIV, S_FMUL_LO, S_FMUL_HI, S_FSHIFT, S_WRITE
	} state_t;

	state_t              state_q;
	pps_pkg::cmd_t       cmd_q;
	logic signed [63:0]  e_q;
	logic signed [39:0]  ec_q;
	logic signed [7:0]   k_q;
	logic signed [40:0]  r_q;
	logic [29:0]         acc_q;
	logic [57:0]         prod_q;
	logic [3:0]          n_q;
	logic [73:0]         pp_q;
	logic [43:0]         res_q;
	logic [43:0]         price_q;
	logic                out_valid_q;
	logic [43:0]         out_price_q;
	logic [15:0]         out_idx_q;
	logic                out_last_q;
	logic                out_ovr_q;

	logic [15:0]         mag;
	logic [63:0]         dprod;
	logic [63:0]         qt;
	logic signed [63:0]  e_next;
	logic signed [39:0]  ec_next;
	logic signed [41:0]  kprod;
	logic signed [40:0]  kl;
	logic signed [40:0]  r_next;
	logic [29:0]         v;
	logic [65:0]         dq;
	logic [29:0]         acc_next;
	logic [51:0]         pl;
	logic [51:0]         ph;
	logic [43:0]         geo_res;
	logic [6:0]          rsh;
	logic [6:0]          lsh;
	logic [73:0]         gt;
	logic [65:0]         psh;
	logic signed [65:0]  asum;
	logic [65:0]         at;
	logic [43:0]         arith_res;
	logic                out_load;

	assign pop      = (state_q == S_IDLE) && !q_st.empty;
	assign out_load = (state_q == S_WRITE) && (!out_valid_q || result.ready);

	assign result.valid      = out_valid_q;
	assign result.price      = out_price_q;
	assign result.step_index = out_idx_q;
	assign result.last       = out_last_q;
	assign result.overrun    = out_ovr_q;

	// e = drift + diffusion*z, product cut toward zero
	always_comb begin
		mag    = cmd_q.z[15] ? 16'(~cmd_q.z + 16'd1) : 16'(cmd_q.z);
		dprod  = 64'(cfg.diffusion_coef) * 64'(mag);
		qt     = dprod >> Z_FRAC_BITS;
		e_next = $signed({{16{cfg.drift_coef[47]}}, cfg.drift_coef}) +
			$signed(cmd_q.z[15] ? (~qt + 64'd1) : qt);
	end

	// clamp to +-64, k estimate, remainder
	always_comb begin
		if (e_q > pps_pkg::E_CLAMP) begin
			ec_next = 40'(pps_pkg::E_CLAMP);
		end else if (e_q < -pps_pkg::E_CLAMP) begin
			ec_next = 40'(-pps_pkg::E_CLAMP);
		end else begin
			ec_next = e_q[39:0];
		end
		kprod  = $signed(ec_q[39:16]) * $signed({1'b0, pps_pkg::RECIP_LN2});
		kl     = k_q * $signed({1'b0, pps_pkg::LN2_Q32});
		r_next = $signed({ec_q[39], ec_q}) - kl;
	end

	// Horner term: acc = 1 + ((acc*r) >> 28) / n
	always_comb begin
		v  = prod_q[57:28];
		dq = 66'(v) * 66'(pps_pkg::recip_n(n_q));
		acc_next = pps_pkg::ONE_Q28 + ((n_q == 4'd1) ? v : dq[65:36]);
		pl = 52'(price_q[21:0]) * 52'(acc_q);
		ph = 52'(price_q[43:22]) * 52'(acc_q);
	end

	// price * exp(r) * 2^k with saturation
	always_comb begin
		rsh = '0;
		lsh = '0;
		gt  = '0;
		if (k_q <= 8'sd28) begin
			rsh     = 7'(8'sd28 - k_q);
			gt      = pp_q >> rsh;
			geo_res = (gt > {30'd0, pps_pkg::PRICE_MAX}) ? pps_pkg::PRICE_MAX : gt[43:0];
		end else begin
			lsh = 7'(k_q - 8'sd28);
			gt  = pp_q << lsh;
			if (pp_q == '0) begin
				geo_res = '0;
			end else if (lsh >= 7'd44) begin
				geo_res = pps_pkg::PRICE_MAX;
			end else if (pp_q > ({30'd0, pps_pkg::PRICE_MAX} >> lsh)) begin
				geo_res = pps_pkg::PRICE_MAX;
			end else begin
				geo_res = gt[43:0];
			end
		end
	end

	// arithmetic mode: add at 32 fraction bits, floor negatives
	always_comb begin
		psh  = {22'd0, price_q} << ASH;
		asum = $signed(psh) + $signed({{2{e_q[63]}}, e_q});
		at   = 66'(asum) >> ASH;
		if (asum[65]) begin
			arith_res = FLOOR;
		end else begin
			arith_res = (at > {22'd0, pps_pkg::PRICE_MAX}) ? pps_pkg::PRICE_MAX : at[43:0];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			e_q         <= '0;
			ec_q        <= '0;
			k_q         <= '0;
			r_q         <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			n_q         <= '0;
			pp_q        <= '0;
			res_q       <= '0;
			price_q     <= '0;
			out_valid_q <= 1'b0;
			out_price_q <= '0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovr_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_price_q <= res_q;
				out_idx_q   <= cmd_q.step_index;
				out_last_q  <= cmd_q.last;
				out_ovr_q   <= cmd_q.overrun;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (!q_st.empty) begin
						cmd_q <= head;
						if (head.op == pps_pkg::OP_STEP) begin
							state_q <= S_EMUL;
						end else begin
							res_q   <= (head.op == pps_pkg::OP_RESTART) ?
								cfg.start_price : price_q;
							state_q <= S_WRITE;
						end
					end
				end
				S_EMUL: begin
					e_q     <= e_next;
					state_q <= cfg.model_mode ? S_ARITH : S_CLAMP;
				end
				S_ARITH: begin
					res_q   <= arith_res;
					state_q <= S_WRITE;
				end
				S_CLAMP: begin
					ec_q    <= ec_next;
					state_q <= S_KEST;
				end
				S_KEST: begin
					k_q     <= kprod[39:32];
					state_q <= S_RSUB;
				end
				S_RSUB: begin
					r_q     <= r_next;
					state_q <= S_RFIX;
				end
				S_RFIX: begin
					// estimate is off by at most one either way
					if (r_q < 41'sd0) begin
						k_q <= k_q - 8'sd1;
						r_q <= r_q + LN2_S;
					end else if (r_q >= LN2_S) begin
						k_q <= k_q + 8'sd1;
						r_q <= r_q - LN2_S;
					end
					acc_q   <= pps_pkg::ONE_Q28;
					n_q     <= pps_pkg::POLY_TERMS;
					state_q <= S_PMUL;
				end
				S_PMUL: begin
					prod_q  <= 58'(acc_q) * 58'(r_q[31:4]);
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					acc_q <= acc_next;
					if (n_q == 4'd1) begin
						state_q <= S_FMUL_LO;
					end else begin
						n_q     <= n_q - 4'd1;
						state_q <= S_PMUL;
					end
				end
				S_FMUL_LO: begin
					pp_q    <= {22'd0, pl};
					state_q <= S_FMUL_HI;
				end
				S_FMUL_HI: begin
					pp_q    <= pp_q + {ph, 22'd0};
					state_q <= S_FSHIFT;
				end
				S_FSHIFT: begin
					res_q   <= geo_res;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_load) begin
						price_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PMUL) |-> (r_q >= 41'sd0 && r_q < LN2_S))
		else $error("reduced argument out of range");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FSHIFT) |-> (k_q >= -8'sd94 && k_q <= 8'sd94))
		else $error("exponent out of range");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not registered");

endmodule

/* design/price_path_step.sv */
// ----------------------------------------------------------------------------
// price_path_step: one step of a simulated price path per normal sample
// Top level: APB configuration, sample intake, command queue, price engine.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: kind = 0 restarts the path at start_price (step 0),
//   kind = 1 advances it by one step with sample z (Q4.12). Every sample
//   gives exactly one transfer on the result channel: price (Q20.24),
//   step_index, last and overrun, in sample order.
//   Configuration is written over APB (64-bit data, register i at 8*i).
//   The user must write it only while no sample is in flight; unchecked.
//   Timing: the front takes a sample per cycle while the two-entry queue
//   has room. The back engine takes one command at a time and registers
//   its result; a restart or overrun goes straight to the write state,
//   an arithmetic step adds e, and a geometric step runs the exp() Horner
//   loop over ten terms, each a multiply state and then a divide state.
//   Reset (arst_n low) clears the path to price 0, step 0, empties the
//   queue and loads register defaults.
//   A stalled result receiver holds the result register; the engine then
//   waits in its write state and the queue, then the sample channel, fill.
// ----------------------------------------------------------------------------
module price_path_step #(
	parameter int unsigned PRICE_FRAC_BITS = 24,
	parameter int unsigned Z_FRAC_BITS     = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pps_pkg::PADDR_W-1:0]   paddr,
	input  logic [pps_pkg::PDATA_W-1:0]   pwdata,
	output logic [pps_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	pps_sample_if.sink                    sample,
	pps_result_if.source                  result
);

	pps_pkg::cfg_t       cfg;
	pps_pkg::cmd_t       push_cmd;
	pps_pkg::cmd_t       head;
	pps_pkg::q_status_t  q_st;
	logic                push;
	logic                pop;

	pps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.step_limit (cfg.step_limit),
		.q_st       (q_st),
		.push       (push),
		.cmd        (push_cmd)
	);

	pps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.st       (q_st)
	);

	pps_back #(
		.PRICE_FRAC_BITS (PRICE_FRAC_BITS),
		.Z_FRAC_BITS     (Z_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.q_st   (q_st),
		.pop    (pop),
		.result (result)
	);

endmodule

/* tb/price_path_step_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// price_path_step_tb: self-checking bench for the price path step block
// Drives restart and step samples over the stream channel, sweeps the
// register settings over APB between phases, and checks each result
// against a bit-exact price predictor kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module price_path_step_tb;

	localparam bit          KIND_RESTART = 1'b0;
	localparam bit          KIND_STEP    = 1'b1;
	localparam logic [43:0] FLOOR_PRICE  = 44'(((64'd1 << 24) + 64'd50) / 64'd100);
	localparam longint      CLAMP_E      = 64'sd64 <<< 32;
	localparam longint      LN2          = 64'sd2977044472;
	localparam int          CYCLE_LIMIT  = 600000;
	localparam int          DRAIN_CYCLES = 60;

	typedef struct {
		logic [43:0] price;
		logic [15:0] step_index;
		logic        last;
		logic        overrun;
	} price_out_t;

	// Scoreboard: path predictor plus the queue of expected prices
	class price_book;
		pps_pkg::cfg_t cfg;
		logic [43:0]   path_price;
		logic [15:0]   step_count;
		price_out_t    expected_q[$];
		int            mismatches;
		int            checked;
		int            overruns;
		int            floors;

		function new();
			cfg.model_mode     = 1'b0;
			cfg.start_price    = pps_pkg::START_RST;
			cfg.drift_coef     = '0;
			cfg.diffusion_coef = '0;
			cfg.step_limit     = 16'd1;
			path_price         = '0;
			step_count         = '0;
			mismatches         = 0;
			checked            = 0;
			overruns           = 0;
			floors             = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] value);
			case (idx)
				pps_pkg::REG_MODEL_MODE:     cfg.model_mode     = value[0];
				pps_pkg::REG_START_PRICE:    cfg.start_price    = value[43:0];
				pps_pkg::REG_DRIFT_COEF:     cfg.drift_coef     = value[47:0];
				pps_pkg::REG_DIFFUSION_COEF: cfg.diffusion_coef = value[47:0];
				pps_pkg::REG_STEP_LIMIT:     cfg.step_limit     = value[15:0];
				default: ;
			endcase
		endfunction

		// price * exp(e): range reduction by ln2, degree-10 Horner in Q.28
		function logic [43:0] exp_step(logic [43:0] p, longint e);
			longint       k;
			longint       r;
			logic [63:0]  r28;
			logic [63:0]  acc;
			logic [127:0] prod;
			logic [255:0] wide;
			if (e > CLAMP_E) e = CLAMP_E;
			if (e < -CLAMP_E) e = -CLAMP_E;
			if (e >= 0) k = e / LN2;
			else k = -((-e + LN2 - 1) / LN2);
			r = e - k * LN2;
			r28 = 64'(r) >> 4;
			acc = 64'd1 << 28;
			for (int n = 10; n >= 1; n--)
				acc = (64'd1 << 28) + ((acc * r28) >> 28) / 64'(n);
			prod = 128'(p) * 128'(acc);
			if (k <= 28) wide = 256'(prod) >> int'(28 - k);
			else wide = 256'(prod) << int'(k - 28);
			return (wide > 256'(pps_pkg::PRICE_MAX)) ? pps_pkg::PRICE_MAX : wide[43:0];
		endfunction

		// price + e at 32 fraction bits, negative sums floored
		function logic [43:0] add_step(logic [43:0] p, longint e);
			longint sum;
			sum = longint'(64'(p) << 8) + e;
			if (sum < 0) begin
				floors++;
				return FLOOR_PRICE;
			end
			sum = sum >>> 8;
			return (sum > longint'(pps_pkg::PRICE_MAX)) ? pps_pkg::PRICE_MAX : sum[43:0];
		endfunction

		function void note_sample(logic kind, logic signed [15:0] z);
			price_out_t  res;
			longint      zl;
			logic [63:0] mag;
			logic [63:0] q;
			longint      e;
			longint      drift;
			res.overrun = 1'b0;
			if (kind == KIND_RESTART) begin
				path_price = cfg.start_price;
				step_count = '0;
			end else if (step_count >= cfg.step_limit) begin
				res.overrun = 1'b1;
				overruns++;
			end else begin
				zl = z;
				mag = 64'(zl < 0 ? -zl : zl);
				q = (64'(cfg.diffusion_coef) * mag) >> 12;
				drift = $signed(cfg.drift_coef);
				e = drift + (zl < 0 ? -longint'(q) : longint'(q));
				path_price = cfg.model_mode ? add_step(path_price, e)
					: exp_step(path_price, e);
				step_count = step_count + 16'd1;
			end
			res.price      = path_price;
			res.step_index = step_count;
			res.last       = (step_count == cfg.step_limit);
			expected_q.insert(expected_q.size(), res);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
				checked, what, got, want);
		endtask

		task check_result(logic [43:0] price, logic [15:0] idx, logic last,
			logic overrun);
			price_out_t want;
			if (expected_q.size() == 0) begin
				report("unexpected transfer, price", 64'(price), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (price !== want.price) report("price", 64'(price), 64'(want.price));
				if (idx !== want.step_index)
					report("step_index", 64'(idx), 64'(want.step_index));
				if (last !== want.last) report("last", 64'(last), 64'(want.last));
				if (overrun !== want.overrun)
					report("overrun", 64'(overrun), 64'(want.overrun));
			end
			checked++;
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [pps_pkg::PADDR_W-1:0]   paddr;
	logic [pps_pkg::PDATA_W-1:0]   pwdata;
	logic [pps_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	bit                            quiet;
	int                            cycles = 0;
	int                            samples_sent;
	price_book                     sb;

	pps_sample_if sample_ch ();
	pps_result_if result_ch ();

	price_path_step i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: random stalls, check every transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.price, result_ch.step_index, result_ch.last,
					result_ch.overrun);
			result_ch.ready <= quiet || ($urandom_range(99) >= 19);
		end
	end

	task write_reg(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task send_sample(logic kind, logic signed [15:0] z);
		if (!quiet && $urandom_range(99) < 19) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.kind  <= kind;
		sample_ch.z     <= z;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(kind, z);
		samples_sent++;
	endtask

	// Let the pipeline empty before touching registers
	task drain();
		sample_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_z();
		return 16'($urandom_range(65535));
	endfunction

	task set_all(logic mode, logic [43:0] sp, logic [47:0] drift, logic [47:0] dif,
		logic [15:0] lim);
		write_reg(pps_pkg::REG_MODEL_MODE, 64'(mode));
		write_reg(pps_pkg::REG_START_PRICE, 64'(sp));
		write_reg(pps_pkg::REG_DRIFT_COEF, 64'(drift));
		write_reg(pps_pkg::REG_DIFFUSION_COEF, 64'(dif));
		write_reg(pps_pkg::REG_STEP_LIMIT, 64'(lim));
	endtask

	initial begin
		logic [43:0] sp;
		logic [47:0] drift;
		logic [47:0] dif;
		logic [15:0] lim;
		int          n_items;
		sb              = new();
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		sample_ch.valid = 1'b0;
		sample_ch.kind  = 1'b0;
		sample_ch.z     = '0;
		quiet           = 1'b0;
		samples_sent    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: steps before any restart, then the default path and overrun
		send_sample(KIND_STEP, 16'sd4096);
		send_sample(KIND_STEP, -16'sd4096);
		send_sample(KIND_RESTART, 16'sh7fff);
		send_sample(KIND_STEP, -16'sd32768);
		send_sample(KIND_STEP, 16'sd32767);
		drain();

		// Geometric extremes: huge growth saturates, huge decay hits zero
		set_all(1'b0, 44'd100 << 24, 48'h7fff_ffff_ffff, 48'hffff_ffff_ffff, 16'd4);
		send_sample(KIND_RESTART, 16'sd0);
		send_sample(KIND_STEP, 16'sd32767);
		send_sample(KIND_STEP, 16'sd0);
		drain();
		write_reg(pps_pkg::REG_DRIFT_COEF, 64'(48'h8000_0000_0000));
		send_sample(KIND_STEP, -16'sd32768);
		send_sample(KIND_STEP, 16'sd1);
		send_sample(KIND_STEP, 16'sd1);
		drain();

		// Arithmetic: floor on a negative sum, zero sum keeps price zero, saturation
		set_all(1'b1, 44'd0, 48'h0, 48'h0000_0001_0000, 16'd0);
		send_sample(KIND_RESTART, 16'sd0);
		send_sample(KIND_STEP, 16'sd5);
		drain();
		write_reg(pps_pkg::REG_STEP_LIMIT, 64'd65535);
		send_sample(KIND_STEP, 16'sd0);
		send_sample(KIND_STEP, -16'sd32768);
		send_sample(KIND_STEP, 16'sd32767);
		drain();
		set_all(1'b1, pps_pkg::PRICE_MAX, 48'h7fff_ffff_ffff, 48'hffff_ffff_ffff, 16'd3);
		send_sample(KIND_RESTART, 16'sd0);
		send_sample(KIND_STEP, 16'sd32767);
		send_sample(KIND_STEP, -16'sd32768);
		send_sample(KIND_STEP, 16'sd0);
		send_sample(KIND_STEP, 16'sd0);
		drain();

		// Random phases of well-formed paths with some noise
		for (int ph = 0; ph < 14; ph++) begin
			quiet = (ph == 3);
			case ($urandom_range(4))
				0: sp = 44'($urandom_range(1000)) << 24;
				1: sp = {12'($urandom), 32'($urandom)};
				2: sp = 44'd100 << 24;
				default: sp = 44'($urandom_range(500, 20)) << 24;
			endcase
			if ($urandom_range(5) == 0) drift = {16'($urandom), 32'($urandom)};
			else drift = 48'($signed(32'($urandom_range(1 << 22))) - (1 << 21));
			if ($urandom_range(5) == 0) dif = {16'($urandom), 32'($urandom)};
			else dif = 48'($urandom_range(1 << 26));
			if (ph == 7) lim = 16'd65535;
			else lim = 16'($urandom_range(40, 1));
			set_all(ph[0] ^ 1'($urandom_range(1)), sp, drift, dif, lim);
			n_items = 45;
			send_sample(KIND_RESTART, rand_z());
			for (int i = 0; i < n_items; i++) begin
				if (ph == 5 && i == 20) drain();
				if ($urandom_range(99) < 7) send_sample(KIND_RESTART, rand_z());
				else send_sample(KIND_STEP, rand_z());
			end
			drain();
		end

		$display("ran %0d samples, %0d results checked, %0d overruns, %0d floored",
			samples_sent, sb.checked, sb.overruns, sb.floors);
		$display("both price modes, register extremes and stall patterns exercised");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* price_path_step.f */
design/pps_pkg.sv
design/pps_if.sv
design/pps_regs.sv
design/pps_front.sv
design/pps_queue.sv
design/pps_back.sv
design/price_path_step.sv
tb/price_path_step_tb.sv
